FILE: rtl/knws_pkg.sv
// Package for the Korean number word sequencer: token codes, slot codes,
// queue entry type and the slot-to-token lookup. No dependencies.
`timescale 1ns / 1ps

package knws_pkg;

  localparam int unsigned CountW    = 17;
  localparam int unsigned TokW      = 4;
  localparam int unsigned DigW      = 4;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned NumSlots  = 11;
  localparam int unsigned SlotW     = 4;

  localparam logic [CountW-1:0] MaxCount = CountW'(99999);

  // Divide by ten: multiply by reciprocal, shift, then one correction step
  localparam int unsigned RecipTen   = 6553;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned ProdW      = 30;
  localparam int unsigned QuotW      = ProdW - RecipShift;

  localparam logic [DigW-1:0] DigTen = DigW'(10);

  localparam int unsigned QueueDepthDef = 2;

  // Token codes
  localparam logic [TokW-1:0] TokNoun     = TokW'(0);
  localparam logic [TokW-1:0] TokTen      = TokW'(10);
  localparam logic [TokW-1:0] TokHundred  = TokW'(11);
  localparam logic [TokW-1:0] TokThousand = TokW'(12);
  localparam logic [TokW-1:0] TokTenThou  = TokW'(13);
  localparam logic [TokW-1:0] TokSuffix   = TokW'(14);

  // Slot codes: position of each possible token in the spoken sequence
  localparam logic [SlotW-1:0] SlotNoun     = SlotW'(0);
  localparam logic [SlotW-1:0] SlotDig4     = SlotW'(1);
  localparam logic [SlotW-1:0] SlotTenThou  = SlotW'(2);
  localparam logic [SlotW-1:0] SlotDig3     = SlotW'(3);
  localparam logic [SlotW-1:0] SlotThousand = SlotW'(4);
  localparam logic [SlotW-1:0] SlotDig2     = SlotW'(5);
  localparam logic [SlotW-1:0] SlotHundred  = SlotW'(6);
  localparam logic [SlotW-1:0] SlotDig1     = SlotW'(7);
  localparam logic [SlotW-1:0] SlotTen      = SlotW'(8);
  localparam logic [SlotW-1:0] SlotDig0     = SlotW'(9);
  localparam logic [SlotW-1:0] SlotSuffix   = SlotW'(10);

  // Digit 0 is the ones place, digit 4 the ten-thousands place
  typedef logic [NumDigits-1:0][DigW-1:0] digit_vec_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;    // one bit per slot that is spoken
    digit_vec_t          digits;
  } entry_t;

  function automatic logic [TokW-1:0] slot_token(input logic [SlotW-1:0] slot,
                                                 input digit_vec_t        digits);
    logic [TokW-1:0] tok;
    tok = TokSuffix;
    case (slot)
      SlotNoun:     tok = TokNoun;
      SlotDig4:     tok = digits[4];
      SlotTenThou:  tok = TokTenThou;
      SlotDig3:     tok = digits[3];
      SlotThousand: tok = TokThousand;
      SlotDig2:     tok = digits[2];
      SlotHundred:  tok = TokHundred;
      SlotDig1:     tok = digits[1];
      SlotTen:      tok = TokTen;
      SlotDig0:     tok = digits[0];
      default:      tok = TokSuffix;
    endcase
    return tok;
  endfunction

endpackage

FILE: rtl/knws_front.sv
// Front end: accepts a count, saturates it, splits it into decimal digits
// one per cycle and builds the spoken-slot mask. Uses knws_pkg.
`timescale 1ns / 1ps

module knws_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [knws_pkg::CountW-1:0] count_i,
  output logic                    push_valid_o,
  input  logic                    push_ready_i,
  output knws_pkg::entry_t        push_data_o
);
  import knws_pkg::*;

  localparam logic [2:0] LastStep = 3'(NumDigits - 1);

  logic              busy_q, busy_d;
  logic              full_q, full_d;
  logic [2:0]        step_q, step_d;
  logic [CountW-1:0] val_q, val_d;
  digit_vec_t        dig_q, dig_d;

  logic              accept, push;
  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [CountW-1:0] quot_x10, rem;
  logic              fix;
  logic [DigW-1:0]   digit;
  logic [CountW-1:0] quot_fixed;
  logic [CountW-1:0] sat;

  // Reciprocal estimate is exact or one low; one compare corrects it
  assign prod       = ProdW'(val_q) * ProdW'(RecipTen);
  assign quot       = prod[ProdW-1:RecipShift];
  assign quot_x10   = CountW'({quot, 3'b000}) + CountW'({quot, 1'b0});
  assign rem        = val_q - quot_x10;
  assign fix        = rem[DigW:0] >= {1'b0, DigTen};
  assign digit      = fix ? DigW'(rem[DigW:0] - {1'b0, DigTen}) : rem[DigW-1:0];
  assign quot_fixed = CountW'(quot) + CountW'(fix);

  assign sat = (count_i > MaxCount) ? MaxCount : count_i;

  assign push         = full_q && push_ready_i;
  assign in_ready_o   = !busy_q || push;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = full_q;

  always_comb begin
    push_data_o.digits = dig_q;
    push_data_o.mask   = '0;
    push_data_o.mask[SlotNoun]     = 1'b1;
    push_data_o.mask[SlotDig4]     = dig_q[4] > DigW'(1);
    push_data_o.mask[SlotTenThou]  = dig_q[4] != '0;
    push_data_o.mask[SlotDig3]     = dig_q[3] > DigW'(1);
    push_data_o.mask[SlotThousand] = dig_q[3] != '0;
    push_data_o.mask[SlotDig2]     = dig_q[2] > DigW'(1);
    push_data_o.mask[SlotHundred]  = dig_q[2] != '0;
    push_data_o.mask[SlotDig1]     = dig_q[1] > DigW'(1);
    push_data_o.mask[SlotTen]      = dig_q[1] != '0;
    push_data_o.mask[SlotDig0]     = dig_q[0] != '0;
    push_data_o.mask[SlotSuffix]   = 1'b1;
  end

  always_comb begin
    busy_d = busy_q;
    full_d = full_q;
    step_d = step_q;
    val_d  = val_q;
    dig_d  = dig_q;
    if (push) begin
      busy_d = 1'b0;
      full_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      full_d = 1'b0;
      step_d = '0;
      val_d  = sat;
    end else if (busy_q && !full_q) begin
      dig_d[step_q] = digit;
      val_d         = quot_fixed;
      if (step_q == LastStep) begin
        full_d = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      full_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      full_q <= full_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    dig_q <= dig_d;
  end

endmodule

FILE: rtl/knws_fifo.sv
// Short queue of classified entries between front and back end.
// Uses knws_pkg for the entry type.
`timescale 1ns / 1ps

module knws_fifo #(
  parameter int unsigned Depth = knws_pkg::QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  knws_pkg::entry_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output knws_pkg::entry_t rd_data_o
);
  import knws_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          store_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            wr, rd;

  assign wr_ready_o = cnt_q != CntW'(Depth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = store_q[rd_ptr_q];
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (wr && !rd) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd && !wr) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      store_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

FILE: rtl/knws_back.sv
// Back end: walks the slot mask of one entry and emits one word token per
// beat through an output register. Uses knws_pkg.
`timescale 1ns / 1ps

module knws_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      entry_valid_i,
  output logic                      entry_ready_o,
  input  knws_pkg::entry_t          entry_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [knws_pkg::TokW-1:0] out_token_o,
  output logic                      out_last_o
);
  import knws_pkg::*;

  logic                active_q;
  entry_t              cur_q;
  logic                out_valid_q;
  logic [TokW-1:0]     out_tok_q;
  logic                out_last_q;

  logic                out_free, emit, last_emit, pop;
  logic [SlotW-1:0]    slot;

  // Lowest pending slot is the next word to say
  always_comb begin
    slot = SlotSuffix;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (cur_q.mask[i]) begin
        slot = SlotW'(i);
      end
    end
  end

  assign out_free      = !out_valid_q || out_ready_i;
  assign emit          = active_q && out_free;
  assign last_emit     = emit && (slot == SlotSuffix);
  assign pop           = entry_valid_i && (!active_q || last_emit);
  assign entry_ready_o = !active_q || last_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        active_q <= 1'b1;
      end else if (last_emit) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= entry_i;
    end else if (emit) begin
      cur_q.mask <= cur_q.mask & ~(NumSlots'(1) << slot);
    end
    if (emit) begin
      out_tok_q  <= slot_token(slot, cur_q.digits);
      out_last_q <= slot == SlotSuffix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_token_o = out_tok_q;
  assign out_last_o  = out_last_q;

endmodule

FILE: rtl/korean_number_word_sequencer.sv
// Korean number word sequencer, top level. Needs knws_pkg, knws_front, knws_fifo, knws_back.
// Path: an accepted count is split into digits, queued, then sent via the output register.
// Throughput: one word beat per cycle while the sink is ready; a count takes 2 to 11 beats,
// and the front end (one digit per cycle) takes no new count until it pushes the last one.
// Reset: rst_ni clears all handshake and sequencing state at once; no clearing pass.
`timescale 1ns / 1ps

module korean_number_word_sequencer #(
  parameter int unsigned QueueDepth = knws_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Count input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [16:0] count_value, rest zero
  // Word output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [3:0] word_token, rest zero
  output logic        m_axis_tlast_o    // last_word
);
  import knws_pkg::*;

  entry_t          fe_data, q_data;
  logic            fe_valid, fe_ready;
  logic            q_valid, q_ready;
  logic [TokW-1:0] token;

  // Front end: hold the count, split it into digits and decide which slots are spoken
  knws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .count_i      (s_axis_tdata_i[CountW-1:0]),
    .push_valid_o (fe_valid),
    .push_ready_i (fe_ready),
    .push_data_o  (fe_data)
  );

  // Decouple the digit splitter from the word emitter so each can stall alone
  knws_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  // Back end: advance through the spoken slots, one beat each; the next entry
  // is taken in the same cycle as the closing suffix beat
  knws_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .entry_valid_i (q_valid),
    .entry_ready_o (q_ready),
    .entry_i       (q_data),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_token_o   (token),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(8 - TokW)'(0), token};

endmodule
